// ===== rtl/core/task_scheduler_with_tick_wakeup_defines.svh =====
// assertion macros for the task scheduler checker
`ifndef TASK_SCHEDULER_WITH_TICK_WAKEUP_DEFINES_SVH
`define TASK_SCHEDULER_WITH_TICK_WAKEUP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define TS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define TS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/tsched_pkg.sv =====
// package with operation codes and sizes of the task scheduler
`default_nettype none
package tsched_pkg;
    localparam int TASKS_DEF = 8;
    localparam int TIMERS_DEF = 4;
    localparam int OP_W = 4;
    localparam int TGT_W = 3;
    localparam int TIDX_W = 2;
    localparam int EXP_W = 4;
    localparam logic [OP_W-1:0] OP_TICK = 4'd0;
    localparam logic [OP_W-1:0] OP_SWITCH = 4'd1;
    localparam logic [OP_W-1:0] OP_SUSPEND = 4'd2;
    localparam logic [OP_W-1:0] OP_WAIT = 4'd3;
    localparam logic [OP_W-1:0] OP_TAKE = 4'd4;
    localparam logic [OP_W-1:0] OP_ACTIVATE = 4'd5;
    localparam logic [OP_W-1:0] OP_SET_DELAY = 4'd6;
    localparam logic [OP_W-1:0] OP_SET_TIMER = 4'd7;
    localparam logic [OP_W-1:0] OP_SET_INACT = 4'd8;
    localparam logic [1:0] WAIT_DELAY = 2'b01;
    localparam logic [1:0] WAIT_TIMER = 2'b10;
    // compare unit request and answer
    typedef struct packed {
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] addend;
    } t_cmp_req;
    typedef struct packed {
        logic        equal;
        logic [31:0] sum;
    } t_cmp_rsp;
endpackage
`default_nettype wire

// ===== rtl/core/tsched_cmp.sv =====
// shared compare and add unit
`default_nettype none
module tsched_cmp
    import tsched_pkg::*;
(
    input  t_cmp_req i_req,
    output t_cmp_rsp o_rsp
);
    assign o_rsp.equal = (i_req.lhs == i_req.rhs);
    assign o_rsp.sum   = i_req.rhs + i_req.addend;
endmodule
`default_nettype wire

// ===== rtl/core/task_scheduler_with_tick_wakeup.sv =====
// top level of the task scheduler with tick wakeup
// One item at a time. A tick first skips the supervisor, then per task after it
// does one delay compare plus a read step and a compare step per timer, all
// through one shared compare/add unit and one timer-table port, then an update
// step and an output capture step. A switch walks the ready bits one task a
// cycle; other operations go through the update and output capture steps. The
// result item is held in an output register and the next item is taken at the
// earliest at the edge where that result is taken. Timer deadlines and periods
// live in a memory cleared after reset by a pass over all TASKS*TIMERS_PER_TASK
// entries during which no item is accepted.
`default_nettype none
module task_scheduler_with_tick_wakeup
    import tsched_pkg::*;
#(
    parameter int TASKS = TASKS_DEF,
    parameter int TIMERS_PER_TASK = TIMERS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [TGT_W-1:0]  i_target,
    input  wire logic [31:0]       i_value,
    input  wire logic [31:0]       i_reload,
    input  wire logic [TIDX_W-1:0] i_timer_index,
    input  wire logic              i_flag,
    input  wire logic [1:0]        i_events,
    input  wire logic [31:0]       i_reason,
    input  wire logic [31:0]       i_wake_detail,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [TGT_W-1:0]       o_running_task,
    output logic [31:0]            o_stack_pointer,
    output logic [31:0]            o_wakeup_reason,
    output logic [31:0]            o_wakeup_detail,
    output logic [EXP_W-1:0]       o_timers_expired
);
    localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int JW = (TIMERS_PER_TASK > 1) ? $clog2(TIMERS_PER_TASK) : 1;
    localparam int NT = TASKS * TIMERS_PER_TASK;
    localparam int KW = (NT > 1) ? $clog2(NT) : 1;
    localparam int EW = (TIMERS_PER_TASK > EXP_W) ? TIMERS_PER_TASK : EXP_W;

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_TASK  = 3'd2;
    localparam logic [2:0] S_TRD   = 3'd3;
    localparam logic [2:0] S_TCMP  = 3'd4;
    localparam logic [2:0] S_PICK  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;

    // per-task state in flip-flops
    logic [TASKS-1:0] r_ready, r_inact;
    logic [1:0]       r_wait  [TASKS];
    logic [31:0]      r_delay [TASKS];
    logic [EW-1:0]    r_exp   [TASKS];
    logic [31:0]      r_rsn   [TASKS];
    logic [31:0]      r_det   [TASKS];
    logic [31:0]      r_sp    [TASKS];
    logic [NT-1:0]    r_forever;
    logic [TW-1:0]    r_cur;

    // timer memory: deadline and period in one word
    logic [63:0] r_tmem [NT];
    logic [63:0] r_trd;

    // latched item
    logic [OP_W-1:0]  r_op;
    logic [TGT_W-1:0] r_tgt;
    logic [31:0]      r_val, r_rel, r_rsn_in, r_det_in;
    logic [TIDX_W-1:0] r_tidx;
    logic             r_flag;
    logic [1:0]       r_ev;

    // scan position
    logic [TW-1:0] r_t;
    logic [JW-1:0] r_j;
    logic [KW-1:0] r_clr;
    logic          r_hit;   // timer matches of this task are ignored in this scan step

    logic r_ovalid;
    logic r_show;           // output registers hold the final state
    logic [TGT_W-1:0] r_o_task;
    logic [31:0] r_o_sp, r_o_rsn, r_o_det;
    logic [EXP_W-1:0] r_o_exp;

    t_cmp_req s_req;
    t_cmp_rsp s_rsp;
    tsched_cmp u_cmp (.i_req(s_req), .o_rsp(s_rsp));

    logic s_take, s_tok, s_jok, s_last_j, s_last_t;
    logic [KW-1:0] s_k;
    assign s_k = KW'(r_t * TIMERS_PER_TASK + r_j);
    assign s_tok = (32'(r_tgt) < TASKS);
    assign s_jok = (32'(r_tidx) < TIMERS_PER_TASK);
    assign s_last_j = (32'(r_j) == TIMERS_PER_TASK - 1);
    assign s_last_t = (32'(r_t) == TASKS - 1);

    // a new item goes in only in the idle state, when no result waits or it leaves at this edge
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && !(r_show && !i_stall));
    assign s_take  = i_valid && !o_stall;

    always_comb begin
        s_req.lhs    = r_val;
        s_req.rhs    = (r_state == S_TASK) ? r_delay[r_t] : r_trd[31:0];
        s_req.addend = r_trd[63:32];
    end

    // task eligible for wakeup in the tick scan
    logic s_elig;
    assign s_elig = !r_inact[r_t] && !r_ready[r_t];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (32'(r_clr) == NT - 1) n_state = S_IDLE;
            S_IDLE:  if (s_take) begin
                if (i_operation == OP_TICK) n_state = S_TASK;
                else if (i_operation == OP_SWITCH && 32'(r_cur) != TASKS - 1)
                    n_state = S_PICK;
                else n_state = S_OUT;
            end
            S_TASK:  n_state = (r_t == '0) ? S_TASK : S_TRD;
            S_TRD:   n_state = S_TCMP;
            S_TCMP:  n_state = s_last_j ? (s_last_t ? S_OUT : S_TASK) : S_TRD;
            S_PICK:  if (r_ready[r_t] || s_last_t) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_cur    <= '0;
            r_ready  <= '0;
            r_inact  <= '0;
            r_forever <= '0;
            for (int i = 0; i < TASKS; i++) begin
                r_wait[i]  <= '0;
                r_delay[i] <= '0;
                r_exp[i]   <= '0;
                r_rsn[i]   <= '0;
                r_det[i]   <= '0;
                r_sp[i]    <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (s_take) begin
                    r_op <= i_operation; r_tgt <= i_target; r_val <= i_value;
                    r_rel <= i_reload; r_tidx <= i_timer_index; r_flag <= i_flag;
                    r_ev <= i_events; r_rsn_in <= i_reason; r_det_in <= i_wake_detail;
                    r_t <= (i_operation == OP_SWITCH) ? TW'(r_cur + 1'b1) : '0;
                    r_j <= '0;
                    if (i_operation == OP_SWITCH) begin
                        r_sp[r_cur] <= i_value;
                        // last task wraps straight to the supervisor
                        if (32'(r_cur) == TASKS - 1) r_cur <= '0;
                    end
                end
                S_TASK: begin
                    r_j   <= '0;
                    r_hit <= r_inact[r_t] || r_ready[r_t] || !r_wait[r_t][1];
                    if (r_t == '0) r_t <= TW'(1);
                    else if (s_elig && r_wait[r_t][0] && s_rsp.equal) begin
                        r_ready[r_t] <= 1'b1;
                        r_rsn[r_t]   <= r_rsn[r_t] | 32'(WAIT_DELAY);
                        r_det[r_t]   <= '0;
                    end
                end
                S_TRD: ;
                S_TCMP: begin
                    if (!r_hit && s_rsp.equal) begin
                        r_ready[r_t] <= 1'b1;
                        r_exp[r_t][r_j] <= 1'b1;
                        r_rsn[r_t] <= r_rsn[r_t] | 32'(WAIT_TIMER);
                        r_det[r_t] <= 32'(r_j);
                    end
                    if (s_last_j) begin
                        r_j <= '0;
                        if (!s_last_t) r_t <= r_t + 1'b1;
                    end else r_j <= r_j + 1'b1;
                end
                S_PICK: begin
                    if (r_ready[r_t]) r_cur <= r_t;
                    else if (s_last_t) r_cur <= '0;
                    else r_t <= r_t + 1'b1;
                end
                S_OUT: begin
                    case (r_op)
                        OP_SUSPEND: begin
                            r_ready[r_cur] <= 1'b0; r_inact[r_cur] <= 1'b0;
                        end
                        OP_WAIT: begin
                            r_wait[r_cur] <= r_ev;
                            r_ready[r_cur] <= 1'b0; r_inact[r_cur] <= 1'b0;
                        end
                        OP_TAKE: r_rsn[r_cur] <= '0;
                        OP_ACTIVATE: if (s_tok) begin
                            r_rsn[TW'(r_tgt)] <= r_rsn[TW'(r_tgt)] | r_rsn_in;
                            r_det[TW'(r_tgt)] <= r_det[TW'(r_tgt)] | r_det_in;
                            r_inact[TW'(r_tgt)] <= 1'b0;
                            r_ready[TW'(r_tgt)] <= 1'b1;
                        end
                        OP_SET_DELAY: if (s_tok) r_delay[TW'(r_tgt)] <= r_val;
                        OP_SET_TIMER: if (s_tok && s_jok)
                            r_forever[KW'(r_tgt * TIMERS_PER_TASK + r_tidx)] <= r_flag;
                        OP_SET_INACT: if (s_tok) r_inact[TW'(r_tgt)] <= r_flag;
                        default: ;
                    endcase
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result taken from state after the last update of the item
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && r_ovalid && !r_show) begin
            r_o_task <= TGT_W'(r_cur);
            r_o_sp   <= r_sp[r_cur];
            r_o_rsn  <= r_rsn[r_cur];
            r_o_det  <= r_det[r_cur];
            r_o_exp  <= r_exp[r_cur][EXP_W-1:0];
        end
    end

    // timer memory port
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) r_tmem[r_clr] <= '0;
        else if (r_state == S_OUT && r_op == OP_SET_TIMER && s_tok && s_jok)
            r_tmem[KW'(r_tgt * TIMERS_PER_TASK + r_tidx)] <= {r_rel, r_val};
        else if (r_state == S_TCMP && !r_hit && s_rsp.equal && r_forever[s_k])
            r_tmem[s_k] <= {r_trd[63:32], s_rsp.sum};
        r_trd <= r_tmem[s_k];
    end

    // output view is flagged valid in the cycle after the update so it shows the final state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_show <= 1'b0;
        else if (r_state == S_IDLE && r_ovalid && !r_show) r_show <= 1'b1;
        else if (o_valid && !i_stall) r_show <= 1'b0;
    end
    assign o_valid = r_ovalid && r_show;
    assign o_running_task   = r_o_task;
    assign o_stack_pointer  = r_o_sp;
    assign o_wakeup_reason  = r_o_rsn;
    assign o_wakeup_detail  = r_o_det;
    assign o_timers_expired = r_o_exp;
endmodule
`default_nettype wire

// ===== rtl/core/tsched_checker.sv =====
// port-level checker for the task scheduler, bound to the top level
`default_nettype none
`include "task_scheduler_with_tick_wakeup_defines.svh"
module tsched_checker
    import tsched_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic [TGT_W-1:0] o_running_task
);
    // an accepted item keeps the block busy the next cycle
    `TS_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // a held result keeps its task index
    `TS_ASSERT_NEXT(a_hold_task, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_running_task))
    // a result is taken before another item goes in
    `TS_ASSERT_IMP(a_no_take_while_stalled, i_clk, i_rst_n, o_valid && i_stall, o_stall)
endmodule
bind task_scheduler_with_tick_wakeup tsched_checker u_tsched_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the task scheduler with tick wakeup
`timescale 1ns / 1ps
`default_nettype none
module testbench
    import tsched_pkg::*;
;

    localparam int NTASK = 8;
    localparam int NTMR = 4;
    localparam int RANDOM_ITEMS = 1300;
    localparam longint CYCLE_LIMIT = 600000;

    // one input item as offered to the block
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TGT_W-1:0]  tgt;
        logic [31:0]       value;
        logic [31:0]       reload;
        logic [TIDX_W-1:0] tidx;
        logic              flag;
        logic [1:0]        events;
        logic [31:0]       reason;
        logic [31:0]       detail;
    } t_cmd;

    // one result item of the block
    typedef struct packed {
        logic [TGT_W-1:0] task_idx;
        logic [31:0]      sp;
        logic [31:0]      reason;
        logic [31:0]      detail;
        logic [EXP_W-1:0] expired;
    } t_view;

    // directed row: item plus an optional typed-in result
    typedef struct packed {
        t_cmd  cmd;
        logic  has_view;
        t_view view;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [OP_W-1:0] i_operation;
    logic [TGT_W-1:0] i_target;
    logic [31:0] i_value;
    logic [31:0] i_reload;
    logic [TIDX_W-1:0] i_timer_index;
    logic i_flag;
    logic [1:0] i_events;
    logic [31:0] i_reason;
    logic [31:0] i_wake_detail;
    logic o_valid;
    logic i_stall;
    logic [TGT_W-1:0] o_running_task;
    logic [31:0] o_stack_pointer;
    logic [31:0] o_wakeup_reason;
    logic [31:0] o_wakeup_detail;
    logic [EXP_W-1:0] o_timers_expired;

    task_scheduler_with_tick_wakeup dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_target(i_target), .i_value(i_value),
        .i_reload(i_reload), .i_timer_index(i_timer_index), .i_flag(i_flag),
        .i_events(i_events), .i_reason(i_reason), .i_wake_detail(i_wake_detail),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_running_task(o_running_task), .o_stack_pointer(o_stack_pointer),
        .o_wakeup_reason(o_wakeup_reason), .o_wakeup_detail(o_wakeup_detail),
        .o_timers_expired(o_timers_expired)
    );

    // ---------------- scheduler shadow state ----------------
    logic [2:0]  sh_cur;
    logic        sh_ready    [NTASK];
    logic        sh_inact    [NTASK];
    logic [1:0]  sh_wait     [NTASK];
    logic [31:0] sh_delay    [NTASK];
    logic [31:0] sh_tdead    [NTASK*NTMR];
    logic [31:0] sh_tper     [NTASK*NTMR];
    logic        sh_tforever [NTASK*NTMR];
    logic [3:0]  sh_expired  [NTASK];
    logic [31:0] sh_reason   [NTASK];
    logic [31:0] sh_detail   [NTASK];
    logic [31:0] sh_sp       [NTASK];

    t_view pending_views[$];
    logic  row_check[$];      // 1 when a typed-in directed result applies
    t_view row_views[$];

    int  errors = 0;
    int  sent = 0;
    int  received = 0;
    int  wakeups_seen = 0;
    int  switches_seen = 0;
    bit  stim_done = 0;
    bit  quiet = 0;           // no idling in the last part of the run
    bit  hold_rx = 0;         // long receiver hold-off request
    longint cycles = 0;

    function automatic void shadow_clear();
        sh_cur = '0;
        for (int t = 0; t < NTASK; t++) begin
            sh_ready[t] = 0; sh_inact[t] = 0; sh_wait[t] = '0; sh_delay[t] = '0;
            sh_expired[t] = '0; sh_reason[t] = '0; sh_detail[t] = '0; sh_sp[t] = '0;
        end
        for (int k = 0; k < NTASK*NTMR; k++) begin
            sh_tdead[k] = '0; sh_tper[k] = '0; sh_tforever[k] = 0;
        end
    endfunction

    // tick: wake waiting tasks whose delay or timer deadline hits now
    function automatic void shadow_tick(logic [31:0] now);
        int k;
        for (int t = 1; t < NTASK; t++) begin
            if (sh_inact[t] || sh_ready[t]) continue;
            if (sh_wait[t][0] && sh_delay[t] == now) begin
                sh_ready[t] = 1;
                sh_reason[t] |= 32'(WAIT_DELAY);
                sh_detail[t] = '0;
                wakeups_seen++;
            end
            if (sh_wait[t][1]) begin
                for (int j = 0; j < NTMR; j++) begin
                    k = t*NTMR + j;
                    if (sh_tdead[k] == now) begin
                        sh_ready[t] = 1;
                        if (sh_tforever[k]) sh_tdead[k] = now + sh_tper[k];
                        sh_expired[t][j] = 1'b1;
                        sh_reason[t] |= 32'(WAIT_TIMER);
                        sh_detail[t] = 32'(j);
                        wakeups_seen++;
                    end
                end
            end
        end
    endfunction

    // apply one item to the shadow state and return the expected result
    function automatic t_view scheduler_step(t_cmd c);
        t_view v;
        int    nxt;
        case (c.op)
            OP_TICK: shadow_tick(c.value);
            OP_SWITCH: begin
                sh_sp[sh_cur] = c.value;
                nxt = 0;
                for (int t = int'(sh_cur) + 1; t < NTASK; t++)
                    if (sh_ready[t] && nxt == 0) nxt = t;
                sh_cur = 3'(nxt);
                if (nxt != 0) switches_seen++;
            end
            OP_SUSPEND: begin
                sh_ready[sh_cur] = 0; sh_inact[sh_cur] = 0;
            end
            OP_WAIT: begin
                sh_wait[sh_cur] = c.events;
                sh_ready[sh_cur] = 0; sh_inact[sh_cur] = 0;
            end
            OP_TAKE: sh_reason[sh_cur] = '0;
            OP_ACTIVATE: begin
                sh_reason[c.tgt] |= c.reason;
                sh_detail[c.tgt] |= c.detail;
                sh_inact[c.tgt] = 0;
                sh_ready[c.tgt] = 1;
            end
            OP_SET_DELAY: sh_delay[c.tgt] = c.value;
            OP_SET_TIMER: begin
                sh_tdead[c.tgt*NTMR + c.tidx] = c.value;
                sh_tper[c.tgt*NTMR + c.tidx] = c.reload;
                sh_tforever[c.tgt*NTMR + c.tidx] = c.flag;
            end
            OP_SET_INACT: sh_inact[c.tgt] = c.flag;
            default: ;  // unused codes leave the state alone
        endcase
        v.task_idx = sh_cur;
        v.sp = sh_sp[sh_cur];
        v.reason = sh_reason[sh_cur];
        v.detail = sh_detail[sh_cur];
        v.expired = sh_expired[sh_cur];
        return v;
    endfunction

    function automatic t_cmd blank_cmd(logic [OP_W-1:0] op);
        t_cmd c;
        c = '0;
        c.op = op;
        return c;
    endfunction

    // fully random item, any opcode including unused ones
    function automatic t_cmd noise_cmd();
        t_cmd c;
        c.op = 4'($urandom_range(0, 15));
        c.tgt = 3'($urandom);
        c.value = $urandom;
        c.reload = $urandom;
        c.tidx = 2'($urandom);
        c.flag = 1'($urandom);
        c.events = 2'($urandom);
        c.reason = $urandom;
        c.detail = $urandom;
        return c;
    endfunction

    // ---------------- clock and reset ----------------
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout: sent %0d received %0d", $time, sent, received);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ---------------- receiver side ----------------
    int rx_idle = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_rx) begin
                i_stall <= 1'b1;
            end else if (rx_idle > 0) begin
                rx_idle <= rx_idle - 1;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                rx_idle <= $urandom_range(0, 14);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_view exp_v;
        t_view got;
        t_view row_v;
        logic  chk;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_running_task, o_stack_pointer, o_wakeup_reason,
                   o_wakeup_detail, o_timers_expired};
            received++;
            if (pending_views.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
            end else begin
                exp_v = pending_views.pop_front();
                chk = row_check.pop_front();
                row_v = row_views.pop_front();
                if (chk && row_v != got) begin
                    // typed-in directed value must agree as well
                    $display("%0t directed row: expected %h actual %h",
                             $time, row_v, got);
                    errors++;
                end
                if (got.task_idx != exp_v.task_idx) begin
                    $display("%0t running_task: expected %0d actual %0d",
                             $time, exp_v.task_idx, got.task_idx);
                    errors++;
                end
                if (got.sp != exp_v.sp) begin
                    $display("%0t stack_pointer: expected %h actual %h",
                             $time, exp_v.sp, got.sp);
                    errors++;
                end
                if (got.reason != exp_v.reason) begin
                    $display("%0t wakeup_reason: expected %h actual %h",
                             $time, exp_v.reason, got.reason);
                    errors++;
                end
                if (got.detail != exp_v.detail) begin
                    $display("%0t wakeup_detail: expected %h actual %h",
                             $time, exp_v.detail, got.detail);
                    errors++;
                end
                if (got.expired != exp_v.expired) begin
                    $display("%0t timers_expired: expected %h actual %h",
                             $time, exp_v.expired, got.expired);
                    errors++;
                end
            end
        end
    end

    // ---------------- sender side ----------------
    // present one item, hold it until taken, then maybe idle a burst
    task automatic send_item(t_cmd c, logic has_view, t_view v);
        int gap;
        i_valid <= 1'b1;
        i_operation <= c.op; i_target <= c.tgt; i_value <= c.value;
        i_reload <= c.reload; i_timer_index <= c.tidx; i_flag <= c.flag;
        i_events <= c.events; i_reason <= c.reason; i_wake_detail <= c.detail;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_views.push_back(scheduler_step(c));
        row_check.push_back(has_view);
        row_views.push_back(v);
        sent++;
        if (!quiet && !hold_rx && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            // next call drives valid again; keep it high without a dip
        end
    endtask

    task automatic send(t_cmd c);
        send_item(c, 1'b0, '0);
    endtask

    // well-formed wait/wake sequence with random content
    task automatic wake_scenario();
        t_cmd  c;
        logic [31:0] now;
        int    who;
        now = $urandom;
        who = $urandom_range(1, NTASK - 1);
        // arm delay and timers of one task close to the coming tick
        c = blank_cmd(OP_SET_DELAY); c.tgt = 3'(who);
        c.value = now + 32'($urandom_range(0, 2));
        send(c);
        for (int j = 0; j < $urandom_range(1, 3); j++) begin
            c = blank_cmd(OP_SET_TIMER); c.tgt = 3'(who);
            c.tidx = 2'($urandom); c.flag = 1'($urandom);
            c.value = now + 32'($urandom_range(0, 2));
            c.reload = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3));
            send(c);
        end
        // bring it to run, let it wait on some events, then tick a few times
        c = blank_cmd(OP_ACTIVATE); c.tgt = 3'(who);
        c.reason = ($urandom_range(0, 3) == 0) ? $urandom : '0;
        c.detail = ($urandom_range(0, 3) == 0) ? $urandom : '0;
        send(c);
        for (int s = 0; s < 3; s++) begin
            c = blank_cmd(OP_SWITCH); c.value = $urandom; send(c);
            if (sh_cur == 3'(who)) break;
        end
        c = blank_cmd(($urandom_range(0, 4) == 0) ? OP_SUSPEND : OP_WAIT);
        c.events = 2'($urandom_range(1, 3));
        send(c);
        if ($urandom_range(0, 5) == 0) begin
            c = blank_cmd(OP_SET_INACT); c.tgt = 3'(who); c.flag = 1'($urandom);
            send(c);
        end
        for (int k = 0; k < $urandom_range(1, 4); k++) begin
            c = blank_cmd(OP_TICK); c.value = now + 32'(k); send(c);
        end
        c = blank_cmd(OP_SWITCH); c.value = $urandom; send(c);
        if ($urandom_range(0, 1)) send(blank_cmd(OP_TAKE));
    endtask

    t_row rows[$];

    task automatic add_row(t_cmd c, logic hv, t_view v);
        t_row r;
        r.cmd = c; r.has_view = hv; r.view = v;
        rows.push_back(r);
    endtask

    initial begin
        t_cmd  c;
        t_view z;
        int    n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = '0; i_target = '0; i_value = '0; i_reload = '0;
        i_timer_index = '0; i_flag = 1'b0; i_events = '0; i_reason = '0;
        i_wake_detail = '0;
        shadow_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: a typed result only where it is obvious
        z = '0;
        add_row(blank_cmd(OP_TICK), 1'b1, z);                   // tick on empty table
        c = blank_cmd(OP_SWITCH); c.value = 32'hFFFF_FFFF;       // nothing ready: stay on 0
        z.sp = 32'hFFFF_FFFF;
        add_row(c, 1'b1, z);
        add_row(blank_cmd(OP_TAKE), 1'b1, z);
        add_row(blank_cmd(4'd9), 1'b1, z);                      // unused code
        add_row(blank_cmd(4'd15), 1'b1, z);
        c = blank_cmd(OP_ACTIVATE); c.tgt = 3'd0;
        c.reason = 32'hFFFF_FFFF; c.detail = 32'h8000_0001;
        z.reason = 32'hFFFF_FFFF; z.detail = 32'h8000_0001;
        add_row(c, 1'b1, z);
        add_row(blank_cmd(OP_TAKE), 1'b0, z);
        c = blank_cmd(OP_SET_DELAY); c.tgt = 3'd7; c.value = 32'hFFFF_FFFF;
        add_row(c, 1'b0, z);
        c = blank_cmd(OP_SET_TIMER); c.tgt = 3'd7; c.tidx = 2'd3; c.flag = 1'b1;
        c.value = 32'hFFFF_FFFF; c.reload = 32'hFFFF_FFFF;
        add_row(c, 1'b0, z);
        c = blank_cmd(OP_SET_TIMER); c.tgt = 3'd1; c.tidx = 2'd0;
        c.value = 32'd5; c.reload = 32'd0;
        add_row(c, 1'b0, z);
        c = blank_cmd(OP_ACTIVATE); c.tgt = 3'd7; add_row(c, 1'b0, z);
        c = blank_cmd(OP_ACTIVATE); c.tgt = 3'd1; add_row(c, 1'b0, z);
        c = blank_cmd(OP_SWITCH); c.value = 32'h1234_5678; add_row(c, 1'b0, z);
        c = blank_cmd(OP_WAIT); c.events = 2'b10; add_row(c, 1'b0, z);
        c = blank_cmd(OP_SWITCH); c.value = 32'hA5A5_5A5A; add_row(c, 1'b0, z);
        c = blank_cmd(OP_WAIT); c.events = 2'b11; add_row(c, 1'b0, z);
        c = blank_cmd(OP_SET_INACT); c.tgt = 3'd1; c.flag = 1'b1; add_row(c, 1'b0, z);
        c = blank_cmd(OP_TICK); c.value = 32'd5; add_row(c, 1'b0, z);   // blocked by inactive
        c = blank_cmd(OP_SET_INACT); c.tgt = 3'd1; c.flag = 1'b0; add_row(c, 1'b0, z);
        c = blank_cmd(OP_TICK); c.value = 32'd5; add_row(c, 1'b0, z);   // timer wakes task 1
        c = blank_cmd(OP_TICK); c.value = 32'hFFFF_FFFF; add_row(c, 1'b0, z); // wrap reload
        c = blank_cmd(OP_SWITCH); c.value = 32'd0; add_row(c, 1'b0, z);
        c = blank_cmd(OP_SUSPEND); add_row(c, 1'b0, z);
        c = blank_cmd(OP_SWITCH); c.value = 32'd1; add_row(c, 1'b0, z);
        foreach (rows[i]) send_item(rows[i].cmd, rows[i].has_view, rows[i].view);

        // random part: mostly wait/wake sequences, some noise
        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (n > RANDOM_ITEMS * 8 / 10) quiet = 1;
            if ($urandom_range(0, 3) != 0) begin
                wake_scenario();
                n += 10;
            end else begin
                send(noise_cmd());
                n++;
            end
        end
        stim_done = 1;
        i_valid <= 1'b0;
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        int held;
        wait (sent > 200);
        @(posedge i_clk);
        hold_rx = 1;
        held = 0;
        while (held < 400) begin
            @(posedge i_clk);
            held++;
        end
        hold_rx = 0;
    end

    // end of run
    initial begin
        wait (stim_done);
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d items, %0d results, %0d wakeups, %0d switches to a task",
                 sent, received, wakeups_seen, switches_seen);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
